[rtl/udbtsr_pkg.sv]
// ----------------------------------------------------------------------------
// udbtsr_pkg
// Shared types and fixed widths for the up/down bar trade size ratio block.
// ----------------------------------------------------------------------------
package udbtsr_pkg;

  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int TRD_W   = 16;
  localparam int SUM_W   = 64;
  localparam int RATIO_W = 32;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               price_finite;
    logic [VOL_W-1:0]   volume;
    logic [TRD_W-1:0]   trade_count;
    logic               load_finite;
    logic               last_bar;
  } bar_word_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               ratio_valid;
  } result_word_t;

endpackage

[rtl/up_down_bar_trade_size_ratio_top.sv]
// ----------------------------------------------------------------------------
// up_down_bar_trade_size_ratio_top
// Mean up-bar over mean down-bar trade size ratio, Q(32-F).F.
// ----------------------------------------------------------------------------
// One bar is taken per handshake. A bar that adds nothing (first bar, skipped
// bar, flat price, full count) does not use the divider. A bar that adds its
// trade size runs the shared serial divider for 32+FRACTION_BITS steps. A last
// bar with bars in both directions then adds two 64-step mean divisions and,
// if both means are nonzero, one (64+FRACTION_BITS)-step ratio division before
// the result word is loaded. All of these divisions run on the single
// divider, one quotient bit per cycle. The next bar may be taken while a
// result word waits on the output.
module up_down_bar_trade_size_ratio_top
  import udbtsr_pkg::*;
#(
  parameter int MAX_BARS      = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         bar_valid,
  output logic         bar_ready,
  input  bar_word_t    bar_data,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result_data
);

  localparam int CNT_W  = $clog2(MAX_BARS + 1);
  localparam int DVD_W  = SUM_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SIZE  = 3'd1;
  localparam logic [2:0] S_MEAN  = 3'd2;
  localparam logic [2:0] S_UP    = 3'd3;
  localparam logic [2:0] S_DN    = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_RATIO = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]         state;
  logic [PRICE_W-1:0] prev_price;
  logic               prev_ok;
  logic               have_prev;
  logic [SUM_W-1:0]   up_sum;
  logic [CNT_W-1:0]   up_cnt;
  logic [SUM_W-1:0]   dn_sum;
  logic [CNT_W-1:0]   dn_cnt;
  logic               dir_up;
  logic               last_r;
  logic [RATIO_W-1:0] res_ratio;
  logic               res_ok;

  logic               accept;
  logic               is_up;
  logic               is_dn;
  logic               dir_full;
  logic               qualify;
  logic               div_start;
  logic [STEP_W-1:0]  div_steps;
  logic [DVD_W-1:0]   div_dvd;
  logic [SUM_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_base;
  logic [SUM_W-1:0]   acc_sat;
  logic               out_load;

  assign bar_ready = (state == S_IDLE);
  assign accept    = bar_valid && bar_ready;
  assign is_up     = bar_data.price > prev_price;
  assign is_dn     = bar_data.price < prev_price;
  assign dir_full  = is_up ? (up_cnt >= CNT_W'(MAX_BARS)) : (dn_cnt >= CNT_W'(MAX_BARS));
  assign qualify   = have_prev && prev_ok && bar_data.price_finite && bar_data.load_finite
                     && (bar_data.trade_count != '0) && (is_up || is_dn) && !dir_full;
  assign out_load  = (state == S_OUT) && (!result_valid || result_ready);

  // operand selection for the shared divider
  always_comb begin
    div_start = 1'b0;
    div_steps = STEP_W'(SUM_W);
    div_dvd   = {up_sum, {FRACTION_BITS{1'b0}}};
    div_dvs   = SUM_W'(up_cnt);
    unique case (state)
      S_IDLE: begin
        div_start = accept && qualify;
        div_steps = STEP_W'(VOL_W + FRACTION_BITS);
        div_dvd   = {bar_data.volume, {(DVD_W - VOL_W){1'b0}}};
        div_dvs   = SUM_W'(bar_data.trade_count);
      end
      S_MEAN: begin
        div_start = (up_cnt != '0) && (dn_cnt != '0);
      end
      S_UP: begin
        div_start = div_done;
        div_dvd   = {dn_sum, {FRACTION_BITS{1'b0}}};
        div_dvs   = SUM_W'(dn_cnt);
      end
      S_CHK: begin
        div_start = (up_sum != '0) && (dn_sum != '0);
        div_steps = STEP_W'(DVD_W);
        div_dvs   = dn_sum;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  udbtsr_div #(
    .DVD_W  (DVD_W),
    .DVS_W  (SUM_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // saturating add of the bar size into the selected sum
  always_comb begin
    acc_base = dir_up ? up_sum : dn_sum;
    acc_sum  = {1'b0, acc_base} + {1'b0, div_q[SUM_W-1:0]};
    acc_sat  = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_price   <= '0;
      prev_ok      <= 1'b0;
      have_prev    <= 1'b0;
      up_sum       <= '0;
      up_cnt       <= '0;
      dn_sum       <= '0;
      dn_cnt       <= '0;
      dir_up       <= 1'b0;
      last_r       <= 1'b0;
      res_ratio    <= '0;
      res_ok       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !out_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_price <= bar_data.price;
            prev_ok    <= bar_data.price_finite;
            have_prev  <= 1'b1;
            dir_up     <= is_up;
            last_r     <= bar_data.last_bar;
            if (qualify) begin
              state <= S_SIZE;
            end else if (bar_data.last_bar) begin
              state <= S_MEAN;
            end
          end
        end
        S_SIZE: begin
          if (div_done) begin
            if (dir_up) begin
              up_sum <= acc_sat;
              up_cnt <= up_cnt + CNT_W'(1);
            end else begin
              dn_sum <= acc_sat;
              dn_cnt <= dn_cnt + CNT_W'(1);
            end
            state <= last_r ? S_MEAN : S_IDLE;
          end
        end
        S_MEAN: begin
          if (div_start) begin
            state <= S_UP;
          end else begin
            res_ratio <= '0;
            res_ok    <= 1'b0;
            state     <= S_OUT;
          end
        end
        S_UP: begin
          if (div_done) begin
            up_sum <= div_q[SUM_W-1:0];
            state  <= S_DN;
          end
        end
        S_DN: begin
          if (div_done) begin
            dn_sum <= div_q[SUM_W-1:0];
            state  <= S_CHK;
          end
        end
        S_CHK: begin
          if (div_start) begin
            state <= S_RATIO;
          end else begin
            res_ratio <= '0;
            res_ok    <= 1'b0;
            state     <= S_OUT;
          end
        end
        S_RATIO: begin
          if (div_done) begin
            res_ratio <= (div_q[DVD_W-1:RATIO_W] != '0) ? {RATIO_W{1'b1}}
                                                       : div_q[RATIO_W-1:0];
            res_ok    <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            result_valid <= 1'b1;
            prev_price   <= '0;
            prev_ok      <= 1'b0;
            have_prev    <= 1'b0;
            up_sum       <= '0;
            up_cnt       <= '0;
            dn_sum       <= '0;
            dn_cnt       <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data.ratio       <= res_ratio;
      result_data.ratio_valid <= res_ok;
    end
  end

endmodule

[rtl/udbtsr_div.sv]
// ----------------------------------------------------------------------------
// udbtsr_div
// Shared restoring divider, one quotient bit per cycle. The dividend is
// left aligned; after the requested number of steps the quotient sits in
// the low bits of the dividend register.
// ----------------------------------------------------------------------------
module udbtsr_div #(
  parameter int DVD_W  = 80,
  parameter int DVS_W  = 64,
  parameter int STEP_W = $clog2(DVD_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  logic              busy;
  logic [STEP_W-1:0] count;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      count <= steps;
    end else if (busy) begin
      dvd   <= {dvd[DVD_W-2:0], ge};
      rem   <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      count <= count - STEP_W'(1);
    end
  end

  assign quotient = dvd;

endmodule

[rtl/udbtsr_checker.sv]
// ----------------------------------------------------------------------------
// udbtsr_checker
// Port-level checks for the up/down bar trade size ratio block.
// ----------------------------------------------------------------------------
module udbtsr_checker
  import udbtsr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         bar_valid,
  input logic         bar_ready,
  input bar_word_t    bar_data,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result_data
);

  // a pending result word holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result word changed or dropped while stalled");

  // a last bar always leads to a busy phase
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    bar_valid && bar_ready && bar_data.last_bar |=> !bar_ready)
    else $error("ready after a last bar");

  // an invalid ratio reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.ratio_valid |-> result_data.ratio == '0)
    else $error("invalid ratio is not zero");

  // a new result word is loaded only out of the busy phase
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!bar_ready))
    else $error("result word appeared while idle");

endmodule

bind up_down_bar_trade_size_ratio_top udbtsr_checker u_udbtsr_checker (
  .clk          (clk),
  .rst          (rst),
  .bar_valid    (bar_valid),
  .bar_ready    (bar_ready),
  .bar_data     (bar_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

[tb/sv/up_down_bar_trade_size_ratio_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// up_down_bar_trade_size_ratio_top_tb
// Self-checking bench for the up/down bar trade size ratio block.
// Bar words go in through a valid/ready sender. A local tracker keeps its own
// up/down sums and counts and queues the ratio word due after each last bar.
// Every result word is compared field by field with the oldest queued one.
// Directed series cover the edge cases, then a long count-full series, a
// receiver hold-off, and random series under four idle patterns.
// ----------------------------------------------------------------------------
module up_down_bar_trade_size_ratio_top_tb;
  import udbtsr_pkg::*;

  localparam int          MAX_BARS  = 4096;
  localparam int          FRAC      = 16;
  localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;

  logic         clk;
  logic         rst          = 1'b1;
  logic         bar_valid    = 1'b0;
  logic         bar_ready;
  bar_word_t    bar_data     = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_word_t result_data;

  // tracker state
  logic [31:0]  last_px    = '0;
  logic         last_px_ok = 1'b0;
  logic         seen_bar   = 1'b0;
  logic [63:0]  up_sum     = '0;
  logic [12:0]  up_cnt     = '0;
  logic [63:0]  dn_sum     = '0;
  logic [12:0]  dn_cnt     = '0;

  result_word_t pending_ratios[$];
  result_word_t want_word;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int fail_count   = 0;
  int bars_sent    = 0;

  up_down_bar_trade_size_ratio_top #(
    .MAX_BARS     (MAX_BARS),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .bar_valid   (bar_valid),
    .bar_ready   (bar_ready),
    .bar_data    (bar_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd80_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bar_word_t make_bar(input logic [31:0] p, input logic pf,
                                         input logic [31:0] v, input logic [15:0] t,
                                         input logic lf, input logic lb);
    bar_word_t w;
    w.price        = p;
    w.price_finite = pf;
    w.volume       = v;
    w.trade_count  = t;
    w.load_finite  = lf;
    w.last_bar     = lb;
    return w;
  endfunction

  function automatic void track_bar(input bar_word_t w);
    logic [63:0]  size;
    logic [64:0]  s;
    logic [63:0]  up_mean;
    logic [63:0]  dn_mean;
    logic [127:0] q;
    result_word_t r;
    if (seen_bar && last_px_ok && w.price_finite && w.load_finite && w.trade_count != 0) begin
      size = ({32'h0, w.volume} << FRAC) / {48'h0, w.trade_count};
      if (w.price > last_px && up_cnt < MAX_BARS) begin
        s      = {1'b0, up_sum} + {1'b0, size};
        up_sum = s[64] ? '1 : s[63:0];
        up_cnt = up_cnt + 1'b1;
      end else if (w.price < last_px && dn_cnt < MAX_BARS) begin
        s      = {1'b0, dn_sum} + {1'b0, size};
        dn_sum = s[64] ? '1 : s[63:0];
        dn_cnt = dn_cnt + 1'b1;
      end
    end
    last_px    = w.price;
    last_px_ok = w.price_finite;
    seen_bar   = 1'b1;
    if (w.last_bar) begin
      r = '0;
      if (up_cnt != 0 && dn_cnt != 0) begin
        up_mean = up_sum / {51'h0, up_cnt};
        dn_mean = dn_sum / {51'h0, dn_cnt};
        if (up_mean != 0 && dn_mean != 0) begin
          q             = ({64'h0, up_mean} << FRAC) / {64'h0, dn_mean};
          r.ratio       = (q > {96'h0, RATIO_MAX}) ? RATIO_MAX : q[31:0];
          r.ratio_valid = 1'b1;
        end
      end
      pending_ratios.push_back(r);
      last_px    = '0;
      last_px_ok = 1'b0;
      seen_bar   = 1'b0;
      up_sum     = '0;
      up_cnt     = '0;
      dn_sum     = '0;
      dn_cnt     = '0;
    end
  endfunction

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_ratios.size() == 0) begin
        $error("unexpected result word: ratio %0h ratio_valid %0b",
               result_data.ratio, result_data.ratio_valid);
        fail_count++;
      end else begin
        want_word = pending_ratios.pop_front();
        if (result_data.ratio !== want_word.ratio) begin
          $error("ratio: expected %0h, got %0h", want_word.ratio, result_data.ratio);
          fail_count++;
        end
        if (result_data.ratio_valid !== want_word.ratio_valid) begin
          $error("ratio_valid: expected %0b, got %0b",
                 want_word.ratio_valid, result_data.ratio_valid);
          fail_count++;
        end
      end
    end
  end

  task automatic send_bar(input bar_word_t w);
    bar_data  <= w;
    bar_valid <= 1'b1;
    @(posedge clk);
    while (!bar_ready) @(posedge clk);
    track_bar(w);
    bars_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      bar_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_drained();
    bar_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic bar_word_t rand_bar(input logic [31:0] prev, input logic lb,
                                         input bit noise);
    bar_word_t   w;
    logic [31:0] dp;
    int          sel;
    dp  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000, 1);
    sel = $urandom_range(9);
    if (sel < 4)       w.price = prev + dp;
    else if (sel < 7)  w.price = prev - dp;
    else if (sel == 7) w.price = prev;
    else if (sel == 8) w.price = $urandom;
    else               w.price = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    w.price_finite = noise ? 1'($urandom_range(1)) : ($urandom_range(19) != 0);
    w.load_finite  = noise ? 1'($urandom_range(1)) : ($urandom_range(19) != 0);
    sel = $urandom_range(19);
    if (sel == 0)       w.trade_count = 16'h0;
    else if (sel <= 10) w.trade_count = 16'($urandom_range(16, 1));
    else if (sel <= 15) w.trade_count = 16'($urandom_range(1000, 1));
    else if (sel <= 18) w.trade_count = 16'($urandom);
    else                w.trade_count = 16'hFFFF;
    sel = $urandom_range(9);
    if (sel == 0)      w.volume = 32'h0;
    else if (sel <= 4) w.volume = $urandom_range(10000);
    else if (sel <= 7) w.volume = $urandom;
    else if (sel == 8) w.volume = 32'hFFFF_FFFF;
    else               w.volume = $urandom_range(100, 1);
    w.last_bar = lb;
    return w;
  endfunction

  task automatic send_random_series();
    int          len;
    int          k;
    bit          noise;
    logic [31:0] px;
    bar_word_t   w;
    k = $urandom_range(99);
    if (k < 5)       len = 1;
    else if (k < 85) len = $urandom_range(12, 2);
    else             len = $urandom_range(40, 13);
    noise = ($urandom_range(7) == 0);
    px    = $urandom;
    for (k = 0; k < len; k++) begin
      w  = rand_bar(px, k == len - 1, noise);
      px = w.price;
      send_bar(w);
    end
  endtask

  task automatic test_single_bar_series();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_bar(make_bar(32'h0, 1'b0, 32'h0, 16'h0, 1'b0, 1'b1));
    send_bar(make_bar(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_up_down_basic();
    send_bar(make_bar(32'd100, 1'b1, 32'd10,   16'd1,  1'b1, 1'b0));
    send_bar(make_bar(32'd200, 1'b1, 32'd1000, 16'd10, 1'b1, 1'b0));
    send_bar(make_bar(32'd50,  1'b1, 32'd3000, 16'd7,  1'b1, 1'b0));
    send_bar(make_bar(32'd50,  1'b1, 32'd999,  16'd1,  1'b1, 1'b0));
    send_bar(make_bar(32'd80,  1'b1, 32'd5000, 16'd3,  1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_skipped_bars();
    // first bar not finite, then each finiteness and zero-count skip in turn
    send_bar(make_bar(32'd10, 1'b0, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd20, 1'b1, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd30, 1'b0, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd40, 1'b1, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd50, 1'b1, 32'd100, 16'd1, 1'b0, 1'b0));
    send_bar(make_bar(32'd60, 1'b1, 32'd100, 16'd0, 1'b1, 1'b0));
    send_bar(make_bar(32'd70, 1'b1, 32'd7,   16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd65, 1'b1, 32'd9,   16'd2, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_zero_and_missing_means();
    // up mean of zero
    send_bar(make_bar(32'd10, 1'b1, 32'd0,   16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd20, 1'b1, 32'd0,   16'd5, 1'b1, 1'b0));
    send_bar(make_bar(32'd5,  1'b1, 32'd100, 16'd1, 1'b1, 1'b1));
    // no down bars at all
    send_bar(make_bar(32'd10, 1'b1, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd20, 1'b1, 32'd100, 16'd1, 1'b1, 1'b0));
    send_bar(make_bar(32'd30, 1'b1, 32'd300, 16'd2, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_ratio_saturation();
    send_bar(make_bar(32'h0,         1'b1, 32'd5,         16'd1,    1'b1, 1'b0));
    send_bar(make_bar(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'd1,    1'b1, 1'b0));
    send_bar(make_bar(32'h0,         1'b1, 32'd1,         16'hFFFF, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_count_full();
    int        k;
    bar_word_t w;
    // alternating prices fill both counts, the tail bars must be dropped
    for (k = 0; k < 8200; k++) begin
      if (k > 8192)
        w = make_bar((k % 2 == 1) ? 32'd200 : 32'd100, 1'b1, 32'hFFFF_FFFF, 16'd1,
                     1'b1, k == 8199);
      else
        w = make_bar((k % 2 == 1) ? 32'd200 : 32'd100, 1'b1, $urandom_range(50000, 1),
                     16'($urandom_range(64, 1)), 1'b1, 1'b0);
      send_bar(w);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    hold_left <= 3000;
    for (k = 0; k < 4; k++) begin
      send_bar(make_bar(32'd10, 1'b1, $urandom_range(1000, 1), 16'd3, 1'b1, 1'b0));
      send_bar(make_bar(32'd20, 1'b1, $urandom, 16'($urandom_range(100, 1)), 1'b1, 1'b0));
      send_bar(make_bar(32'd15, 1'b1, $urandom, 16'($urandom_range(100, 1)), 1'b1, 1'b1));
    end
    wait_drained();
  endtask

  task automatic test_random(input int tx, input int rx, input int items);
    int goal;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    goal         = bars_sent + items;
    while (bars_sent < goal) send_random_series();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_bar_series();
    test_up_down_basic();
    test_skipped_bars();
    test_zero_and_missing_means();
    test_ratio_saturation();
    test_count_full();
    test_backpressure();
    test_random(0, 0, 420);
    test_random(82, 0, 410);
    test_random(0, 82, 410);
    test_random(37, 37, 410);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/udbtsr_pkg.sv
rtl/udbtsr_div.sv
rtl/up_down_bar_trade_size_ratio_top.sv
rtl/udbtsr_checker.sv
tb/sv/up_down_bar_trade_size_ratio_top_tb.sv
